// ===== rtl/mlp_pkg.sv =====
`default_nettype none

package mlp_pkg;

	// Default sizes of the network.
	localparam int HIDDEN_MAX_DEF      = 128;
	localparam int INPUT_COUNT_DEF     = 2;
	localparam int SIGMOID_ENTRIES_DEF = 256;

	// Reset values of the configuration registers.
	localparam logic [15:0] LR_RESET         = 16'd655;
	localparam logic [7:0]  HIDDEN_USE_RESET = 8'd120;

	// Configuration register indexes.
	localparam logic [1:0] REG_LEARNING_RATE = 2'd0;
	localparam logic [1:0] REG_HIDDEN_IN_USE = 2'd1;

	// Command codes.
	localparam logic [1:0] CMD_INFER = 2'd0;
	localparam logic [1:0] CMD_TRAIN = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;
	localparam logic [1:0] CMD_READ  = 2'd3;

	// Saturation bounds of a Q8.16 weight.
	localparam int W_MAX = 8388607;
	localparam int W_MIN = -8388608;

	localparam longint ONE_Q30 = 64'sd1 <<< 30;

	typedef struct packed {
		logic [1:0]         command;
		logic [15:0]        sample_a;
		logic [15:0]        sample_b;
		logic [15:0]        goal;
		logic [9:0]         weight_slot;
		logic signed [23:0] weight_word;
	} item_t;

	typedef struct packed {
		logic [15:0]        prediction;
		logic signed [23:0] weight_read;
	} result_t;

	// Clamp a widened weight sum back into the Q8.16 range.
	function automatic logic signed [23:0] sat24(input logic signed [29:0] v);
		logic signed [23:0] r;
		if (v > 30'(W_MAX)) begin
			r = 24'(W_MAX);
		end else if (v < 30'(W_MIN)) begin
			r = 24'(W_MIN);
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

	// Quotient of two non-negative values by shift and subtract.
	function automatic longint udiv_q(input longint num, input longint den);
		longint q;
		longint r;
		q = 0;
		r = 0;
		for (int b = 62; b >= 0; b--) begin
			r = (r <<< 1) | ((num >>> b) & 64'sd1);
			q = q <<< 1;
			if (r >= den) begin
				r = r - den;
				q = q | 64'sd1;
			end
		end
		return q;
	endfunction

	// Truncated series for exp(-f) in Q30, with f in [0, 1.0].
	function automatic longint exp_neg_q30(input longint f);
		longint s;
		longint term;
		s = ONE_Q30;
		term = ONE_Q30;
		for (int n = 1; n <= 24; n++) begin
			term = udiv_q((term * f) >>> 30, longint'(n));
			if ((n & 1) == 1) begin
				s = s - term;
			end else begin
				s = s + term;
			end
		end
		return s;
	endfunction

	// Sigmoid at the midpoint of bin k of n bins over [-8, 8), in Q0.16.
	// Only evaluated at elaboration to build the lookup table.
	function automatic logic [15:0] sig_entry(input int k, input int n);
		longint e1;
		longint m;
		longint am;
		longint t;
		longint ip;
		longint e;
		longint d;
		longint sp;
		longint v;
		e1 = exp_neg_q30(ONE_Q30);
		m = 2 * longint'(k) + 1 - longint'(n);
		am = (m < 0) ? -m : m;
		t = udiv_q(am <<< 33, longint'(n));
		ip = t >>> 30;
		e = exp_neg_q30(t & (ONE_Q30 - 1));
		for (longint c = 0; c < ip; c++) begin
			e = (e * e1) >>> 30;
		end
		d = ONE_Q30 + e;
		sp = udiv_q((64'sd1 <<< 46) + (d >>> 1), d);
		v = (m > 0) ? sp : 65536 - sp;
		if (v > 65535) begin
			v = 65535;
		end
		if (v < 0) begin
			v = 0;
		end
		return v[15:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/mlp_sigmoid_backprop_train.sv =====
// Infer, train, write and read each run as a sequence of states; infer and train
// loop over the neurons in use, and all steps share one 26x18 multiplier
// and one read port per weight memory.
// One item is worked at a time; busy stays high until the result beat.
// The result is shown for one cycle with done; the receiver cannot stall.
// Reset clears control state and loads the register defaults; weights stay unknown.
`default_nettype none

module mlp_sigmoid_backprop_train
	import mlp_pkg::*;
#(
	parameter int HIDDEN_MAX      = HIDDEN_MAX_DEF,
	parameter int INPUT_COUNT     = INPUT_COUNT_DEF,
	parameter int SIGMOID_ENTRIES = SIGMOID_ENTRIES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire item_t       item,
	output logic             done,
	output result_t          result,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam int HWD     = HIDDEN_MAX * INPUT_COUNT;
	localparam int JW      = (HIDDEN_MAX > 1) ? $clog2(HIDDEN_MAX) : 1;
	localparam int IW      = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;
	localparam int HWA     = (HWD > 1) ? $clog2(HWD) : 1;
	localparam int CW      = $clog2(HIDDEN_MAX + 1);
	localparam int SW      = $clog2(SIGMOID_ENTRIES);
	localparam int HB_BASE = HWD;
	localparam int OW_BASE = HB_BASE + HIDDEN_MAX;
	localparam int OB_SLOT = OW_BASE + HIDDEN_MAX;
	localparam int ACC_W   = 56;

	typedef enum logic [4:0] {
		ST_IDLE, ST_RW, ST_RW_RD,
		ST_H_RD, ST_H_MUL, ST_H_ACC, ST_H_SIG, ST_H_WR,
		ST_O_RD, ST_O_MUL, ST_O_ACC, ST_O_SIG, ST_O_FIN,
		ST_T_D1, ST_T_D2, ST_T_E, ST_T_E2, ST_T_GO, ST_T_GO2,
		ST_N_RD, ST_N_DH, ST_N_T, ST_N_D, ST_N_OW, ST_N_DJ, ST_N_GJ, ST_N_GJ2,
		ST_N_WRD, ST_N_WMUL, ST_N_WWR, ST_T_OB
	} state_t;

	state_t               state_q;
	item_t                item_q;
	logic [15:0]          lr_q;
	logic [7:0]           hid_use_q;
	logic [JW-1:0]        j_q;
	logic [IW-1:0]        i_q;
	logic signed [43:0]   prod_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [SW-1:0]        idx_q;
	logic [15:0]          y_q;
	logic signed [17:0]   der_q;
	logic signed [17:0]   dout_q;
	logic signed [17:0]   go_q;
	logic signed [17:0]   dh_q;
	logic signed [24:0]   t_q;
	logic signed [20:0]   dj_q;
	logic signed [20:0]   gj_q;
	logic signed [23:0]   obias_q;
	logic                 done_q;
	result_t              result_q;

	// Sigmoid lookup table, built at elaboration.
	logic [15:0] sig_rom [SIGMOID_ENTRIES];
	for (genvar k = 0; k < SIGMOID_ENTRIES; k++) begin : g_sig
		assign sig_rom[k] = sig_entry(k, SIGMOID_ENTRIES);
	end

	// Weight and activation memories.
	logic signed [23:0] hw_mem [HWD];
	logic signed [23:0] hb_mem [HIDDEN_MAX];
	logic signed [23:0] ow_mem [HIDDEN_MAX];
	logic [15:0]        act_mem [HIDDEN_MAX];
	logic signed [23:0] hw_rd_q, hb_rd_q, ow_rd_q;
	logic [15:0]        act_rd_q;
	logic [HWA-1:0]     hw_addr;
	logic [JW-1:0]      hb_addr, ow_addr;
	logic               hw_we, hb_we, ow_we, act_we;
	logic signed [23:0] hw_wd, hb_wd, ow_wd;

	// Neurons in use, clamped to [1, HIDDEN_MAX].
	logic [CW-1:0] h_lim;
	always_comb begin
		if (hid_use_q == '0) begin
			h_lim = CW'(1);
		end else if (32'(hid_use_q) > HIDDEN_MAX) begin
			h_lim = CW'(HIDDEN_MAX);
		end else begin
			h_lim = CW'(hid_use_q);
		end
	end

	logic j_last, i_last;
	assign j_last = (CW'(j_q) == h_lim - CW'(1));
	assign i_last = (32'(i_q) == INPUT_COUNT - 1);

	// Current network input; inputs past the second one are zero.
	logic [15:0] x_cur;
	always_comb begin
		if (i_q == IW'(0)) begin
			x_cur = item_q.sample_a;
		end else if (INPUT_COUNT > 1 && 32'(i_q) == 1) begin
			x_cur = item_q.sample_b;
		end else begin
			x_cur = '0;
		end
	end

	// Decode of the flat weight slot.
	int  slot;
	logic in_hw, in_hb, in_ow, in_ob, is_rw;
	assign slot  = int'(item_q.weight_slot);
	assign in_hw = slot < HB_BASE;
	assign in_hb = (slot >= HB_BASE) && (slot < OW_BASE);
	assign in_ow = (slot >= OW_BASE) && (slot < OB_SLOT);
	assign in_ob = slot == OB_SLOT;
	assign is_rw = (state_q == ST_RW) || (state_q == ST_RW_RD);

	// Memory addresses follow the slot for weight beats, else the counters.
	assign hw_addr = is_rw ? HWA'(slot) : HWA'(32'(j_q) * INPUT_COUNT + 32'(i_q));
	assign hb_addr = is_rw ? JW'(slot - HB_BASE) : j_q;
	assign ow_addr = is_rw ? JW'(slot - OW_BASE) : j_q;

	logic signed [27:0] prod_sh;
	assign prod_sh = prod_q[43:16];

	logic wr_cmd;
	assign wr_cmd = (state_q == ST_RW) && (item_q.command == CMD_WRITE);

	// Write enables and write data of the memories.
	assign hw_we  = (wr_cmd && in_hw) || (state_q == ST_N_WWR);
	assign hb_we  = (wr_cmd && in_hb) || (state_q == ST_N_GJ2);
	assign ow_we  = (wr_cmd && in_ow) || (state_q == ST_N_OW);
	assign act_we = state_q == ST_H_WR;
	assign hw_wd  = is_rw ? item_q.weight_word : sat24(30'(hw_rd_q) + 30'(prod_sh));
	assign hb_wd  = is_rw ? item_q.weight_word : sat24(30'(hb_rd_q) + 30'(prod_sh));
	assign ow_wd  = is_rw ? item_q.weight_word : sat24(30'(ow_rd_q) + 30'(prod_sh));

	always_ff @(posedge clk) begin
		if (hw_we) begin
			hw_mem[hw_addr] <= hw_wd;
		end
		hw_rd_q <= hw_mem[hw_addr];
	end

	always_ff @(posedge clk) begin
		if (hb_we) begin
			hb_mem[hb_addr] <= hb_wd;
		end
		hb_rd_q <= hb_mem[hb_addr];
	end

	always_ff @(posedge clk) begin
		if (ow_we) begin
			ow_mem[ow_addr] <= ow_wd;
		end
		ow_rd_q <= ow_mem[ow_addr];
	end

	always_ff @(posedge clk) begin
		if (act_we) begin
			act_mem[j_q] <= sig_rom[idx_q];
		end
		act_rd_q <= act_mem[j_q];
	end

	// Operand select of the shared multiplier.
	logic signed [25:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [16:0] err;
	assign err = $signed({1'b0, item_q.goal}) - $signed({1'b0, y_q});
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_H_MUL: begin
				mul_a = 26'(hw_rd_q);
				mul_b = $signed({2'b00, x_cur});
			end
			ST_O_MUL: begin
				mul_a = 26'(ow_rd_q);
				mul_b = $signed({2'b00, act_rd_q});
			end
			ST_T_D1: begin
				mul_a = $signed({10'd0, y_q});
				mul_b = $signed(18'h10000 - {2'b00, y_q});
			end
			ST_T_E: begin
				mul_a = 26'(err);
				mul_b = der_q;
			end
			ST_T_GO: begin
				mul_a = 26'(dout_q);
				mul_b = $signed({2'b00, lr_q});
			end
			ST_N_DH: begin
				mul_a = $signed({10'd0, act_rd_q});
				mul_b = $signed(18'h10000 - {2'b00, act_rd_q});
			end
			ST_N_T: begin
				mul_a = 26'(ow_rd_q);
				mul_b = dout_q;
			end
			ST_N_D: begin
				mul_a = 26'(go_q);
				mul_b = $signed({2'b00, act_rd_q});
			end
			ST_N_OW: begin
				mul_a = 26'(t_q);
				mul_b = dh_q;
			end
			ST_N_GJ: begin
				mul_a = 26'(dj_q);
				mul_b = $signed({2'b00, lr_q});
			end
			ST_N_WMUL: begin
				mul_a = 26'(gj_q);
				mul_b = $signed({2'b00, x_cur});
			end
			default: begin
			end
		endcase
	end

	// Net input clamped to [-8, 8) and mapped to a table index.
	logic signed [39:0] net;
	logic [19:0]        net_u;
	logic [32:0]        scaled;
	logic [SW-1:0]      idx_c;
	always_comb begin
		net = acc_q[ACC_W-1:16];
		if (net < -40'sd524288) begin
			net_u = '0;
		end else if (net > 40'sd524287) begin
			net_u = '1;
		end else begin
			net_u = {~net[19], net[18:0]};
		end
		scaled = 33'(net_u) * 33'(SIGMOID_ENTRIES);
		idx_c = SW'(scaled >> 20);
	end

	// Read-back value of a weight slot.
	logic signed [23:0] rd_val;
	always_comb begin
		if (in_hw) begin
			rd_val = hw_rd_q;
		end else if (in_hb) begin
			rd_val = hb_rd_q;
		end else if (in_ow) begin
			rd_val = ow_rd_q;
		end else if (in_ob) begin
			rd_val = obias_q;
		end else begin
			rd_val = '0;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q <= LR_RESET;
			hid_use_q <= HIDDEN_USE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LEARNING_RATE: lr_q <= cfg_data;
				REG_HIDDEN_IN_USE: hid_use_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer with its datapath registers and the result beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q <= 1'b0;
			j_q <= '0;
			i_q <= '0;
		end else begin
			done_q <= 1'b0;
			prod_q <= 44'(mul_a * mul_b);
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						item_q <= item;
						j_q <= '0;
						i_q <= '0;
						if (item.command == CMD_WRITE || item.command == CMD_READ) begin
							state_q <= ST_RW;
						end else begin
							state_q <= ST_H_RD;
						end
					end
				end
				ST_RW: begin
					if (item_q.command == CMD_WRITE) begin
						if (in_ob) begin
							obias_q <= item_q.weight_word;
						end
						result_q <= '0;
						done_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_RW_RD;
					end
				end
				ST_RW_RD: begin
					result_q.prediction <= '0;
					result_q.weight_read <= rd_val;
					done_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				// Hidden layer forward pass.
				ST_H_RD: state_q <= ST_H_MUL;
				ST_H_MUL: begin
					if (i_q == IW'(0)) begin
						acc_q <= ACC_W'(hb_rd_q) <<< 16;
					end
					state_q <= ST_H_ACC;
				end
				ST_H_ACC: begin
					acc_q <= acc_q + ACC_W'(prod_q);
					if (i_last) begin
						state_q <= ST_H_SIG;
					end else begin
						i_q <= i_q + IW'(1);
						state_q <= ST_H_RD;
					end
				end
				ST_H_SIG: begin
					idx_q <= idx_c;
					state_q <= ST_H_WR;
				end
				ST_H_WR: begin
					i_q <= '0;
					if (j_last) begin
						j_q <= '0;
						acc_q <= ACC_W'(obias_q) <<< 16;
						state_q <= ST_O_RD;
					end else begin
						j_q <= j_q + JW'(1);
						state_q <= ST_H_RD;
					end
				end
				// Output neuron.
				ST_O_RD: state_q <= ST_O_MUL;
				ST_O_MUL: state_q <= ST_O_ACC;
				ST_O_ACC: begin
					acc_q <= acc_q + ACC_W'(prod_q);
					if (j_last) begin
						state_q <= ST_O_SIG;
					end else begin
						j_q <= j_q + JW'(1);
						state_q <= ST_O_RD;
					end
				end
				ST_O_SIG: begin
					idx_q <= idx_c;
					state_q <= ST_O_FIN;
				end
				ST_O_FIN: begin
					y_q <= sig_rom[idx_q];
					if (item_q.command == CMD_TRAIN) begin
						state_q <= ST_T_D1;
					end else begin
						result_q.prediction <= sig_rom[idx_q];
						result_q.weight_read <= '0;
						done_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				// Output delta and its scaled step.
				ST_T_D1: state_q <= ST_T_D2;
				ST_T_D2: begin
					der_q <= 18'(prod_sh);
					state_q <= ST_T_E;
				end
				ST_T_E: state_q <= ST_T_E2;
				ST_T_E2: begin
					dout_q <= 18'(prod_sh);
					state_q <= ST_T_GO;
				end
				ST_T_GO: state_q <= ST_T_GO2;
				ST_T_GO2: begin
					go_q <= 18'(prod_sh);
					j_q <= '0;
					i_q <= '0;
					state_q <= ST_N_RD;
				end
				// Per neuron: hidden delta from the old output weight, then updates.
				ST_N_RD: state_q <= ST_N_DH;
				ST_N_DH: state_q <= ST_N_T;
				ST_N_T: begin
					dh_q <= 18'(prod_sh);
					state_q <= ST_N_D;
				end
				ST_N_D: begin
					t_q <= 25'(prod_sh);
					state_q <= ST_N_OW;
				end
				ST_N_OW: state_q <= ST_N_DJ;
				ST_N_DJ: begin
					dj_q <= 21'(prod_sh);
					state_q <= ST_N_GJ;
				end
				ST_N_GJ: state_q <= ST_N_GJ2;
				ST_N_GJ2: begin
					gj_q <= 21'(prod_sh);
					i_q <= '0;
					state_q <= ST_N_WRD;
				end
				ST_N_WRD: state_q <= ST_N_WMUL;
				ST_N_WMUL: state_q <= ST_N_WWR;
				ST_N_WWR: begin
					if (!i_last) begin
						i_q <= i_q + IW'(1);
						state_q <= ST_N_WRD;
					end else if (j_last) begin
						state_q <= ST_T_OB;
					end else begin
						i_q <= '0;
						j_q <= j_q + JW'(1);
						state_q <= ST_N_RD;
					end
				end
				ST_T_OB: begin
					obias_q <= sat24(30'(obias_q) + 30'(go_q));
					result_q.prediction <= y_q;
					result_q.weight_read <= '0;
					done_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy   = state_q != ST_IDLE;
	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

// ===== rtl/mlp_checker.sv =====
`default_nettype none

module mlp_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done
);

	// An accepted item always keeps the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not make the block busy");

	// The result beat comes only once the block has gone idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	// Busy ends exactly with a result beat.
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result beat");

	// Every item passes through a busy state before its result beat, so beats never come back to back.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result beats back to back");

endmodule

bind mlp_sigmoid_backprop_train mlp_checker u_mlp_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top
	import mlp_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NH       = HIDDEN_MAX_DEF;
	localparam int NIN      = INPUT_COUNT_DEF;
	localparam int NSIG     = SIGMOID_ENTRIES_DEF;
	localparam int HB_SLOT  = NH * NIN;
	localparam int OW_SLOT  = HB_SLOT + NH;
	localparam int OB_SLOT  = OW_SLOT + NH;
	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE      = 8;

	typedef struct {
		item_t   it;
		bit      known;
		result_t want;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	item_t       item = '0;
	logic        done;
	result_t     result;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	mlp_sigmoid_backprop_train u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// Shadow network state and configuration.
	logic [15:0] sig_lut [NSIG];
	longint      w_hid [NH*NIN];
	longint      b_hid [NH];
	longint      w_out [NH];
	longint      b_out;
	longint      act   [NH];
	longint      dlt   [NH];
	longint      rate_q = LR_RESET;
	int          neurons_q = HIDDEN_USE_RESET;

	result_t     pending_results [$];
	int          beats_in = 0;
	int          errors = 0;
	int          quiet_cycles = 0;
	bit          row_known = 1'b0;
	result_t     row_want = '0;
	bit          allow_gaps = 1'b1;

	// Series for exp(-f) in Q30 used to fill the sigmoid table.
	function automatic longint exp_series(input longint f);
		longint acc;
		longint term;
		acc = 64'sd1 <<< 30;
		term = 64'sd1 <<< 30;
		for (int n = 1; n <= 24; n++) begin
			term = ((term * f) >>> 30) / longint'(n);
			acc = (n % 2 == 1) ? acc - term : acc + term;
		end
		return acc;
	endfunction

	initial begin
		longint e1, m, am, t, ip, e, d, sp, v;
		e1 = exp_series(64'sd1 <<< 30);
		for (int k = 0; k < NSIG; k++) begin
			m = 2 * longint'(k) + 1 - longint'(NSIG);
			am = (m < 0) ? -m : m;
			t = (am <<< 33) / longint'(NSIG);
			ip = t >>> 30;
			e = exp_series(t & ((64'sd1 <<< 30) - 1));
			while (ip > 0) begin
				e = (e * e1) >>> 30;
				ip--;
			end
			d = (64'sd1 <<< 30) + e;
			sp = ((64'sd1 <<< 46) + d / 2) / d;
			v = (m > 0) ? sp : 65536 - sp;
			if (v > 65535) v = 65535;
			if (v < 0) v = 0;
			sig_lut[k] = v[15:0];
		end
	end

	function automatic longint clamp_w(input longint v);
		return (v > W_MAX) ? W_MAX : ((v < W_MIN) ? W_MIN : v);
	endfunction

	function automatic longint squash(input longint net);
		longint n;
		n = (net < -524288) ? -524288 : ((net > 524287) ? 524287 : net);
		return longint'(sig_lut[((n + 524288) * NSIG) >>> 20]);
	endfunction

	function automatic longint slope(input longint a);
		return (a * (65536 - a)) >>> 16;
	endfunction

	// Run one command against the shadow network and return its result.
	function automatic result_t network_step(input item_t it);
		result_t r;
		longint x [NIN];
		longint acc, y, dout, go, gj, tt;
		int h;
		int s;
		r = '0;
		h = (neurons_q < 1) ? 1 : ((neurons_q > NH) ? NH : neurons_q);
		for (int i = 0; i < NIN; i++) x[i] = 0;
		x[0] = it.sample_a;
		if (NIN > 1) x[1] = it.sample_b;
		s = it.weight_slot;
		if (it.command == CMD_INFER || it.command == CMD_TRAIN) begin
			for (int j = 0; j < h; j++) begin
				acc = b_hid[j] * 65536;
				for (int i = 0; i < NIN; i++) acc += w_hid[j*NIN+i] * x[i];
				act[j] = squash(acc >>> 16);
			end
			acc = b_out * 65536;
			for (int j = 0; j < h; j++) acc += w_out[j] * act[j];
			y = squash(acc >>> 16);
			r.prediction = y[15:0];
			if (it.command == CMD_TRAIN) begin
				dout = ((longint'(it.goal) - y) * slope(y)) >>> 16;
				for (int j = 0; j < h; j++) begin
					tt = (dout * w_out[j]) >>> 16;
					dlt[j] = (tt * slope(act[j])) >>> 16;
				end
				go = (rate_q * dout) >>> 16;
				for (int j = 0; j < h; j++) w_out[j] = clamp_w(w_out[j] + ((go * act[j]) >>> 16));
				b_out = clamp_w(b_out + go);
				for (int j = 0; j < h; j++) begin
					gj = (rate_q * dlt[j]) >>> 16;
					for (int i = 0; i < NIN; i++)
						w_hid[j*NIN+i] = clamp_w(w_hid[j*NIN+i] + ((gj * x[i]) >>> 16));
					b_hid[j] = clamp_w(b_hid[j] + gj);
				end
			end
		end else begin
			longint cur;
			bit hit;
			hit = 1'b1;
			if (s < HB_SLOT) cur = w_hid[s];
			else if (s < OW_SLOT) cur = b_hid[s-HB_SLOT];
			else if (s < OB_SLOT) cur = w_out[s-OW_SLOT];
			else if (s == OB_SLOT) cur = b_out;
			else hit = 1'b0;
			if (hit && it.command == CMD_WRITE) begin
				cur = longint'(it.weight_word);
				if (s < HB_SLOT) w_hid[s] = cur;
				else if (s < OW_SLOT) b_hid[s-HB_SLOT] = cur;
				else if (s < OB_SLOT) w_out[s-OW_SLOT] = cur;
				else b_out = cur;
			end else if (hit) begin
				r.weight_read = cur[23:0];
			end
		end
		return r;
	endfunction

	// Result check first, then capture of the accepted command beat.
	always @(posedge clk) begin
		result_t want;
		result_t got;
		if (done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result beat %h", $time, result);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (result.prediction !== want.prediction) begin
					$display("%0t: prediction expected %h actual %h", $time,
						want.prediction, result.prediction);
					errors++;
				end
				if (result.weight_read !== want.weight_read) begin
					$display("%0t: weight_read expected %h actual %h", $time,
						want.weight_read, result.weight_read);
					errors++;
				end
			end
		end
		if (start && !busy) begin
			got = network_step(item);
			pending_results = {pending_results, (row_known ? row_want : got)};
			beats_in++;
		end
		quiet_cycles = (done || (start && !busy)) ? 0 : quiet_cycles + 1;
	end

	// Watchdog on cycles without any handshake.
	always @(posedge clk) begin
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic row_t mk(input logic [1:0] cmd, input logic [15:0] a, input logic [15:0] b,
			input logic [15:0] g, input logic [9:0] slot, input logic [23:0] word,
			input bit known, input logic [15:0] pred, input logic [23:0] rd);
		row_t r;
		r.it.command = cmd;
		r.it.sample_a = a;
		r.it.sample_b = b;
		r.it.goal = g;
		r.it.weight_slot = slot;
		r.it.weight_word = word;
		r.known = known;
		r.want.prediction = pred;
		r.want.weight_read = rd;
		return r;
	endfunction

	// Present one command beat; returns at the falling edge after it is taken.
	task automatic send_cmd(input item_t it, input bit known, input result_t want);
		int seen;
		if (allow_gaps && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		start <= 1'b1;
		item <= it;
		row_known = known;
		row_want = want;
		seen = beats_in;
		do @(negedge clk); while (beats_in == seen);
	endtask

	task automatic drain;
		start <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == REG_LEARNING_RATE) rate_q = val;
		else if (idx == REG_HIDDEN_IN_USE) neurons_q = val[7:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic item_t random_cmd();
		item_t it;
		int pick;
		it.command = 2'($urandom);
		it.sample_a = 16'($urandom);
		it.sample_b = 16'($urandom);
		it.goal = 16'($urandom);
		it.weight_slot = 10'($urandom_range(0, OB_SLOT));
		it.weight_word = 24'($urandom_range(0, 262143) - 131072);
		pick = $urandom_range(0, 99);
		if (pick < 40) it.command = CMD_TRAIN;
		else if (pick < 65) it.command = CMD_INFER;
		else if (pick < 78) it.command = CMD_WRITE;
		else if (pick < 83) begin
			it.command = CMD_WRITE;
			it.weight_word = 24'($urandom);
			if ($urandom_range(0, 1) == 0) it.weight_slot = 10'($urandom);
		end else begin
			it.command = CMD_READ;
			if ($urandom_range(0, 3) == 0) it.weight_slot = 10'($urandom);
		end
		return it;
	endfunction

	initial begin
		row_t rows [$];
		item_t it;
		int n_items;
		int nphase;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Out-of-range slot needs no prior write.
		rows = {rows, mk(CMD_READ, 16'hffff, 16'hffff, 16'hffff, 10'h3ff, 24'h7fffff,
			1, 0, 0)};
		rows = {rows, mk(CMD_WRITE, 0, 0, 0, 10'h3ff, 24'h123456, 1, 0, 0)};
		foreach (rows[k]) send_cmd(rows[k].it, rows[k].known, rows[k].want);
		rows.delete();

		// Load every weight before anything reads it.
		for (int s = 0; s <= OB_SLOT; s++) begin
			it = random_cmd();
			it.command = CMD_WRITE;
			it.weight_slot = 10'(s);
			send_cmd(it, 0, '0);
		end

		// Directed part at the default register values.
		rows = {rows, mk(CMD_WRITE, 0, 0, 0, 10'(OB_SLOT), 24'h7fffff, 1, 0, 0)};
		rows = {rows, mk(CMD_READ, 0, 0, 0, 10'(OB_SLOT), 0, 1, 0, 24'h7fffff)};
		rows = {rows, mk(CMD_INFER, 16'hffff, 16'hffff, 0, 0, 0, 0, 0, 0)};
		rows = {rows, mk(CMD_WRITE, 0, 0, 0, 10'(OB_SLOT), 24'h800000, 1, 0, 0)};
		rows = {rows, mk(CMD_READ, 0, 0, 0, 10'(OB_SLOT), 0, 1, 0, 24'h800000)};
		rows = {rows, mk(CMD_INFER, 0, 0, 0, 0, 0, 0, 0, 0)};
		rows = {rows, mk(CMD_WRITE, 0, 0, 0, 10'(OB_SLOT), 24'h000000, 1, 0, 0)};
		rows = {rows, mk(CMD_WRITE, 0, 0, 0, 10'(OB_SLOT + 1), 24'h7fffff, 1, 0, 0)};
		rows = {rows, mk(CMD_READ, 0, 0, 0, 10'(OB_SLOT + 1), 0, 1, 0, 0)};
		rows = {rows, mk(CMD_TRAIN, 0, 0, 16'hffff, 0, 0, 0, 0, 0)};
		rows = {rows, mk(CMD_TRAIN, 16'hffff, 16'hffff, 0, 0, 0, 0, 0, 0)};
		rows = {rows, mk(CMD_TRAIN, 16'h8000, 16'h0001, 16'h8000, 0, 0, 0, 0, 0)};
		rows = {rows, mk(CMD_INFER, 16'h1234, 16'hfedc, 0, 0, 0, 0, 0, 0)};
		rows = {rows, mk(CMD_READ, 0, 0, 0, 10'd0, 0, 0, 0, 0)};
		rows = {rows, mk(CMD_READ, 0, 0, 0, 10'(HB_SLOT - 1), 0, 0, 0, 0)};
		rows = {rows, mk(CMD_READ, 0, 0, 0, 10'(HB_SLOT), 0, 0, 0, 0)};
		rows = {rows, mk(CMD_READ, 0, 0, 0, 10'(OW_SLOT - 1), 0, 0, 0, 0)};
		rows = {rows, mk(CMD_READ, 0, 0, 0, 10'(OW_SLOT), 0, 0, 0, 0)};
		rows = {rows, mk(CMD_READ, 0, 0, 0, 10'(OB_SLOT - 1), 0, 0, 0, 0)};
		rows = {rows, mk(CMD_READ, 0, 0, 0, 10'(OB_SLOT), 0, 0, 0, 0)};
		foreach (rows[k]) send_cmd(rows[k].it, rows[k].known, rows[k].want);

		// Random phases, each under its own register setting.
		nphase = 12;
		for (int p = 0; p < nphase; p++) begin
			drain();
			n_items = 50;
			case (p)
				0: begin
					write_reg(REG_LEARNING_RATE, 16'hffff);
					write_reg(REG_HIDDEN_IN_USE, 16'd0);
				end
				1: begin
					write_reg(REG_LEARNING_RATE, 16'h0000);
					write_reg(REG_HIDDEN_IN_USE, 16'd255);
					n_items = 8;
				end
				2: begin
					write_reg(REG_LEARNING_RATE, 16'hffff);
					write_reg(REG_HIDDEN_IN_USE, 16'(NH));
					write_reg(REG_SPARE, 16'h0001);
					n_items = 8;
				end
				default: begin
					write_reg(REG_LEARNING_RATE, 16'($urandom));
					write_reg(REG_HIDDEN_IN_USE, 16'($urandom_range(1, 6)));
				end
			endcase
			if (p == nphase - 1) allow_gaps = 1'b0;
			for (int k = 0; k < n_items; k++) send_cmd(random_cmd(), 0, '0);
		end

		drain();
		repeat (20) @(negedge clk);
		if (pending_results.size() != 0) errors++;
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/mlp_pkg.sv
rtl/mlp_sigmoid_backprop_train.sv
rtl/mlp_checker.sv
tb/tb_top.sv
